// ===== rtl/esu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package esu_pkg;

  localparam int unsigned DataW = 32;

  // One signed sample of a block.
  typedef logic signed [DataW-1:0] data_t;

endpackage

`default_nettype wire

// ===== rtl/exchange_sorter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Exchange sorter. Takes blocks of COUNT signed 32-bit samples on the
// slave stream, one sample per transfer, and returns each block on the
// master stream in ascending signed order with tlast on the largest
// (final) value. Once the block is full, row p of the exchange sort
// reads store entry p into a holding register (StRowRd, StRowHold),
// then steps q = p+1 .. COUNT-1 at one compare per cycle, writing the
// held value to entry q and taking entry q in its place whenever the
// held value is greater. The held value is then final and goes out as
// result p, so row p never has to be written back. The sort speed is
// set by the single read port of the store and the one comparator; a
// stalled master stream holds the emit step. The slave side is ready
// only while loading; the output register lets the next block start
// loading while the last result still waits.
module exchange_sorter_unit #(
  parameter int unsigned COUNT = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  // slave stream
  input  wire logic           s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  wire esu_pkg::data_t s_axis_tdata_i,   // [31:0] sample_value
  // master stream
  output logic                m_axis_tvalid_o,
  input  wire logic           m_axis_tready_i,
  output esu_pkg::data_t      m_axis_tdata_o,   // [31:0] sorted_value
  output logic                m_axis_tlast_o    // last_of_block
);
  import esu_pkg::*;

  localparam int unsigned AddrW = (COUNT > 1) ? $clog2(COUNT) : 1;
  localparam logic [AddrW-1:0] LastIdx = AddrW'(COUNT - 1);

  typedef enum logic [2:0] {
    StLoad,
    StRowRd,
    StRowHold,
    StCmp,
    StEmit
  } state_e;

  state_e           state_q;
  logic [AddrW-1:0] load_cnt_q;
  logic [AddrW-1:0] p_q;
  logic [AddrW-1:0] q_q;
  data_t            held_q;
  logic             out_valid_q;
  data_t            out_data_q;
  logic             out_last_q;

  // store port controls
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  data_t            mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  data_t            mem_rdata;

  logic             swap;
  data_t            cmp_min;

  logic in_xfer;
  logic out_free;
  logic emit_fire;

  assign in_xfer   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign emit_fire = (state_q == StEmit) && out_free;

  assign s_axis_tready_o = (state_q == StLoad);

  esu_store #(
    .Depth (COUNT),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  esu_cmp u_cmp (
    .held_i (held_q),
    .cand_i (mem_rdata),
    .swap_o (swap),
    .min_o  (cmp_min)
  );

  // store addressing: load writes by count, compare step writes back the
  // displaced held value and prefetches the next column
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = load_cnt_q;
    mem_wdata = s_axis_tdata_i;
    mem_raddr = p_q;
    unique case (state_q)
      StLoad: begin
        mem_we = in_xfer;
      end
      StRowRd: begin
        mem_raddr = p_q;
      end
      StRowHold: begin
        mem_raddr = q_q;
      end
      StCmp: begin
        mem_we    = swap;
        mem_waddr = q_q;
        mem_wdata = held_q;
        mem_raddr = q_q + AddrW'(1);
      end
      StEmit: begin
        mem_raddr = p_q;
      end
      default: begin
        mem_raddr = p_q;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      load_cnt_q  <= '0;
      p_q         <= '0;
      q_q         <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StLoad: begin
          if (in_xfer) begin
            if (load_cnt_q == LastIdx) begin
              load_cnt_q <= '0;
              p_q        <= '0;
              state_q    <= StRowRd;
            end else begin
              load_cnt_q <= load_cnt_q + AddrW'(1);
            end
          end
        end
        StRowRd: begin
          q_q     <= p_q + AddrW'(1);
          state_q <= StRowHold;
        end
        StRowHold: begin
          held_q <= mem_rdata;
          // last row has no later column
          state_q <= (p_q == LastIdx) ? StEmit : StCmp;
        end
        StCmp: begin
          held_q <= cmp_min;
          if (q_q == LastIdx) begin
            state_q <= StEmit;
          end else begin
            q_q <= q_q + AddrW'(1);
          end
        end
        StEmit: begin
          if (out_free) begin
            out_data_q  <= held_q;
            out_last_q  <= (p_q == LastIdx);
            if (p_q == LastIdx) begin
              p_q     <= '0;
              state_q <= StLoad;
            end else begin
              p_q     <= p_q + AddrW'(1);
              state_q <= StRowRd;
            end
          end
        end
        default: begin
          state_q <= StLoad;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/esu_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Value store: one write port, one read port, registered read data.
module esu_store #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AddrW-1:0]  waddr_i,
  input  wire esu_pkg::data_t    wdata_i,
  input  wire logic [AddrW-1:0]  raddr_i,
  output esu_pkg::data_t         rdata_o
);
  import esu_pkg::*;

  data_t mem_q [Depth];
  data_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/esu_cmp.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Compare unit: flags a swap when the held value is greater
// than the candidate (signed). Equal values never swap.
module esu_cmp (
  input  wire esu_pkg::data_t held_i,
  input  wire esu_pkg::data_t cand_i,
  output logic                swap_o,
  output esu_pkg::data_t      min_o
);
  import esu_pkg::*;

  assign swap_o = held_i > cand_i;
  assign min_o  = swap_o ? cand_i : held_i;

endmodule

`default_nettype wire

// ===== sim/tb_exchange_sorter_unit.sv =====
`timescale 1ns / 1ps

module tb_exchange_sorter_unit;
  import esu_pkg::*;

  localparam int unsigned COUNT        = 16;
  localparam int unsigned RANDOM_ITEMS = 300;
  // drain margin: covers loading and sorting one full block, with slack
  localparam int unsigned DRAIN_CYCLES = 4 * COUNT + COUNT * (COUNT - 1) / 2 + 16;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned MAX_REPORTS  = 10;

  localparam data_t MIN_VAL = 32'sh8000_0000;
  localparam data_t MAX_VAL = 32'sh7fff_ffff;

  // content shape of one random block
  typedef enum int unsigned {
    BLK_RANDOM,
    BLK_NARROW,
    BLK_EDGE,
    BLK_EQUAL,
    BLK_RISING,
    BLK_FALLING
  } block_style_e;

  typedef struct packed {
    data_t value;
    logic  last;
  } sorted_item_t;

  // directed row: sample, plus an optional pinned result for the same slot of the block
  typedef struct {
    data_t sample;
    bit    pinned;
    data_t pinned_val;
  } dir_row_t;

  logic  clk_i;
  logic  rst_ni;
  logic  s_axis_tvalid;
  logic  s_axis_tready;
  data_t s_axis_tdata;
  logic  m_axis_tvalid;
  logic  m_axis_tready;
  data_t m_axis_tdata;
  logic  m_axis_tlast;

  exchange_sorter_unit #(
    .COUNT(COUNT)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),   // [31:0] sample_value
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),   // [31:0] sorted_value
    .m_axis_tlast_o (m_axis_tlast)    // last_of_block
  );

  // predictor state: current block in arrival order
  data_t        block_buf [COUNT];
  bit           pin_ok    [COUNT];
  data_t        pin_val   [COUNT];
  int unsigned  block_fill;
  sorted_item_t sorted_q[$];

  int unsigned  idle_pct;
  int unsigned  stall_pct;
  int unsigned  mismatch_cnt;
  int unsigned  cycle_cnt;

  dir_row_t dir_rows [16] = '{
    '{MAX_VAL,         1'b1, MIN_VAL},  // slot 0: smallest
    '{MIN_VAL,         1'b1, MIN_VAL},  // slot 1: duplicate min
    '{32'sd0,          1'b0, '0},
    '{-32'sd1,         1'b0, '0},
    '{32'sd1,          1'b0, '0},
    '{MAX_VAL,         1'b0, '0},
    '{MIN_VAL,         1'b0, '0},
    '{32'sd5,          1'b0, '0},
    '{32'sd5,          1'b0, '0},
    '{32'sd5,          1'b0, '0},
    '{-32'sd5,         1'b0, '0},
    '{32'sh4000_0000,  1'b0, '0},
    '{32'shc000_0000,  1'b0, '0},
    '{32'sh5555_5555,  1'b0, '0},
    '{32'shaaaa_aaaa,  1'b1, MAX_VAL},  // slot 14: duplicate max
    '{32'sd0,          1'b1, MAX_VAL}   // slot 15: largest, tlast
  };

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // store one accepted sample; a full block yields COUNT sorted expectations
  task automatic take_sample(input data_t v, input bit pin, input data_t pv);
    data_t        work [COUNT];
    data_t        hold;
    sorted_item_t item;
    block_buf[block_fill] = v;
    pin_ok[block_fill]    = pin;
    pin_val[block_fill]   = pv;
    block_fill++;
    if (block_fill == COUNT) begin
      work = block_buf;
      for (int p = 0; p < COUNT - 1; p++) begin
        for (int q = p + 1; q < COUNT; q++) begin
          if (work[p] > work[q]) begin
            hold    = work[p];
            work[p] = work[q];
            work[q] = hold;
          end
        end
      end
      for (int k = 0; k < COUNT; k++) begin
        item.value = pin_ok[k] ? pin_val[k] : work[k];
        item.last  = (k == COUNT - 1);
        sorted_q.push_back(item);
      end
      block_fill = 0;
    end
  endtask

  // drive one sample, optionally after an idle gap, and wait for its transfer
  task automatic send_sample(input data_t v, input bit pin, input data_t pv);
    int unsigned gap;
    gap = 0;
    while (idle_pct != 0 && gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    take_sample(v, pin, pv);
  endtask

  function automatic data_t pick_sample(block_style_e style, data_t base, data_t step,
                                        int unsigned pos);
    data_t v;
    case (style)
      BLK_NARROW:  v = data_t'($urandom_range(15)) - 32'sd8;
      BLK_EDGE: begin
        case ($urandom_range(5))
          0:       v = MIN_VAL;
          1:       v = MAX_VAL;
          2:       v = 32'sd0;
          3:       v = -32'sd1;
          4:       v = MIN_VAL + 32'sd1;
          default: v = MAX_VAL - 32'sd1;
        endcase
      end
      BLK_EQUAL:   v = base;
      BLK_RISING:  v = base + step * data_t'(pos);
      BLK_FALLING: v = base - step * data_t'(pos);
      default:     v = $urandom;
    endcase
    return v;
  endfunction

  task automatic report(input string what, input sorted_item_t want, input sorted_item_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("mismatch (%s): expected data=%h last=%b, got data=%h last=%b",
               what, want.value, want.last, got.value, got.last);
  endtask

  // receiver: random stall per cycle
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  // result check at each accepted output transfer
  always @(posedge clk_i) begin : result_check
    sorted_item_t got;
    sorted_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.value = m_axis_tdata;
      got.last  = m_axis_tlast;
      if (sorted_q.size() == 0) begin
        want = '0;
        report("no result expected", want, got);
      end else begin
        want = sorted_q.pop_front();
        if (got.value !== want.value) report("sorted_value", want, got);
        if (got.last !== want.last) report("last_of_block", want, got);
      end
    end
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    block_style_e style;
    data_t        base;
    data_t        step;
    int unsigned  sent;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    idle_pct      = 0;
    stall_pct     = 0;
    mismatch_cnt  = 0;
    block_fill    = 0;
    style         = BLK_RANDOM;
    base          = '0;
    step          = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: one full block of extremes and duplicates, no idling
    foreach (dir_rows[i])
      send_sample(dir_rows[i].sample, dir_rows[i].pinned, dir_rows[i].pinned_val);

    // random blocks over four idle/stall phases; always end on a block boundary
    sent = 0;
    while (sent < RANDOM_ITEMS || block_fill != 0) begin
      case (sent * 4 / RANDOM_ITEMS)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 61; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      if (block_fill == 0) begin
        case ($urandom_range(9))
          0, 1, 2, 3: style = BLK_RANDOM;
          4:          style = BLK_NARROW;
          5:          style = BLK_EDGE;
          6:          style = BLK_EQUAL;
          7:          style = BLK_RISING;
          default:    style = BLK_FALLING;
        endcase
        base = $urandom;
        step = data_t'($urandom_range(1, 1000));
      end
      send_sample(pick_sample(style, base, step, block_fill), 1'b0, '0);
      sent++;
    end
    s_axis_tvalid <= 1'b0;

    while (sorted_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0 && sorted_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
